[hdl/group_reverse_reorder_assert.svh]
// Assertion macros used by the checker file.
`ifndef GROUP_REVERSE_REORDER_ASSERT_SVH
`define GROUP_REVERSE_REORDER_ASSERT_SVH

// Clocked property, ignored while reset is asserted.
`define GRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge.
`define GRR_ASSERT_NEVER(lbl, cond, msg) \
    `GRR_ASSERT(lbl, !(cond), msg)

`endif

[hdl/grr_pkg.sv]
`default_nettype none

package grr_pkg;

    // Width of the group size register.
    localparam int GS_W = 5;

    // Input word: one sequence element and its end flag.
    typedef struct packed {
        logic signed [31:0] value;
        logic               end_of_list;
    } t_in_word;

    // Output word: reordered element with burst and list end flags.
    typedef struct packed {
        logic signed [31:0] out_value;
        logic               burst_end;
        logic               list_end;
    } t_out_word;

endpackage

`default_nettype wire

[hdl/grr_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module grr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/group_reverse_reorder.sv]
// Group reverse reorder.
// Input channel i_valid / o_ready carries one word per element: a signed
// 32-bit value and an end_of_list flag. Output channel o_valid / i_ready
// carries reordered words with burst_end (last word caused by one input
// word) and list_end (last word of the sequence).
// Words are stored in a group RAM. When the held count reaches the group
// size the group is read back newest first; an end_of_list word with a short
// group reads the held words back oldest first. Other words give no output.
// The user must write the group size (i_cfg_we / i_cfg_data) only while idle.
// An input word that produces nothing leaves the block idle. One that closes
// a burst of n words blocks input while the burst drains: each output word
// passes through a RAM read state and a show state, since the single read
// port feeds the output register directly. The first output word is shown
// after the RAM read state that follows the accepting edge.
// A receiver stall holds the current word and the whole drain; o_ready stays
// low until the last word of the burst is taken.
// Reset (synchronous, active low) empties the group, sets the group size to
// 1 and drops o_valid. RAM contents are not cleared.
`default_nettype none

module group_reverse_reorder #(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [4:0]              i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire grr_pkg::t_in_word       i_in,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output grr_pkg::t_out_word           o_out
);

    import grr_pkg::*;

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GS_W) ? CW : GS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [GS_W-1:0] r_group_size;
    logic [AW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_rev, n_rev;
    logic            r_eol, n_eol;

    logic [KW-1:0]   w_k;
    logic [CW-1:0]   w_n;
    logic            w_accept;
    logic            w_full;
    logic            w_last;
    logic            w_ram_re;
    logic [31:0]     w_rdata;

    // effective group size: zero acts as one, saturate at MAX_GROUP
    always_comb begin
        if (r_group_size == '0) begin
            w_k = KW'(1);
        end else if (KW'(r_group_size) > KW'(MAX_GROUP)) begin
            w_k = KW'(MAX_GROUP);
        end else begin
            w_k = KW'(r_group_size);
        end
    end

    assign w_accept = i_valid && o_ready;
    assign w_n      = CW'(r_fill) + CW'(1);
    assign w_full   = KW'(w_n) >= w_k;
    assign w_last   = (r_cnt == CW'(1));
    assign w_ram_re = (r_state == S_READ);

    // group storage
    grr_ram #(
        .WIDTH (32),
        .DEPTH (MAX_GROUP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_fill),
        .i_wdata (i_in.value),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // sequencer: store, then read each word back via S_READ and S_SHOW
    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_rev   = r_rev;
        n_eol   = r_eol;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_full || i_in.end_of_list) begin
                        n_state = S_READ;
                        n_cnt   = w_n;
                        n_rev   = w_full;
                        n_eol   = i_in.end_of_list;
                        n_idx   = w_full ? r_fill : '0;
                        n_fill  = '0;
                    end else begin
                        n_fill = AW'(w_n);
                    end
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (i_ready) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_idx   = r_rev ? (r_idx - AW'(1)) : (r_idx + AW'(1));
                    n_state = w_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_group_size <= GS_W'(1);
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_group_size <= i_cfg_data;
            end
        end
    end

    // drain bookkeeping
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        r_rev <= n_rev;
        r_eol <= n_eol;
    end

    // handshakes and output word, data straight from the RAM read register
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_SHOW);
    assign o_out.out_value = w_rdata;
    assign o_out.burst_end = w_last;
    assign o_out.list_end  = w_last && r_eol;

endmodule

`default_nettype wire

[hdl/grr_checker.sv]
`default_nettype none
`include "group_reverse_reorder_assert.svh"

// Port-level checks for the group reverse reorder block.
module grr_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire grr_pkg::t_out_word o_out
);

    import grr_pkg::*;

    // a stalled output word holds
    `GRR_ASSERT(a_out_hold, (o_valid && !i_ready) |=> o_valid && $stable(o_out), "stall change")

    // list end only on the last word of a burst
    `GRR_ASSERT_NEVER(a_list_in_burst, o_valid && o_out.list_end && !o_out.burst_end, "lone list_end")

    // input is blocked for the whole drain
    `GRR_ASSERT_NEVER(a_no_overlap, o_valid && o_ready, "input ready while draining")

    // first output word waits for the RAM read state after the accepting edge
    `GRR_ASSERT(a_read_gap, (i_valid && o_ready) |=> !o_valid, "output word without RAM read cycle")

endmodule

bind group_reverse_reorder grr_checker u_grr_checker (.*);

`default_nettype wire
